>>> design/frms_pkg.sv
package frms_pkg;

  localparam int CAND_W      = 16;
  localparam int COUNT_W     = 8;
  localparam int TABLE_DEPTH = 1 << CAND_W;
  localparam int DIV_STEPS   = 33;
  localparam int DIV_CNT_W   = 6;
  localparam int TRIAL_W     = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [CAND_W-1:0]  PRIMES_MAX  = '1;
  localparam logic [COUNT_W-1:0] REQ_DEFAULT = 8'd16;

  // Top-level sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TRIAL_TEST,
    ST_TRIAL_WAIT,
    ST_RECIP_START,
    ST_RECIP_WAIT,
    ST_CLEAR,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_MUL_START,
    ST_MUL_WAIT,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_UPDATE,
    ST_FINISH
  } frms_state_t;

  // Modular multiplier stages
  typedef enum logic [2:0] {
    MM_IDLE,
    MM_QUOT,
    MM_QP,
    MM_SUB,
    MM_FIX1,
    MM_FIX2
  } frms_mm_state_t;

  typedef struct packed {
    logic              start;
    logic [32:0]       dividend;
    logic [CAND_W-1:0] divisor;
  } frms_div_req_t;

  typedef struct packed {
    logic              done;
    logic [31:0]       quot;
    logic [CAND_W-1:0] rem;
  } frms_div_rsp_t;

  typedef struct packed {
    logic              start;
    logic [CAND_W-1:0] a;
    logic [CAND_W-1:0] b;
  } frms_mm_req_t;

  typedef struct packed {
    logic              done;
    logic [CAND_W-1:0] result;
  } frms_mm_rsp_t;

endpackage

>>> design/frms_if.sv
interface frms_in_if;
  import frms_pkg::*;
  logic              valid;
  logic              ready;
  logic [CAND_W-1:0] candidate;
  modport source(output valid, output candidate, input ready);
  modport sink(input valid, input candidate, output ready);
endinterface

interface frms_out_if;
  import frms_pkg::*;
  logic               valid;
  logic               ready;
  logic               candidate_is_prime;
  logic               item_ignored;
  logic [COUNT_W-1:0] local_multiplicity;
  logic [CAND_W-1:0]  mode_residue;
  logic [COUNT_W-1:0] best_multiplicity;
  logic [CAND_W-1:0]  best_prime;
  logic [CAND_W-1:0]  run_residue;
  logic [CAND_W-1:0]  primes_counted;
  logic               witness;
  modport source(output valid, output candidate_is_prime, output item_ignored,
                 output local_multiplicity, output mode_residue,
                 output best_multiplicity, output best_prime, output run_residue,
                 output primes_counted, output witness, input ready);
  modport sink(input valid, input candidate_is_prime, input item_ignored,
               input local_multiplicity, input mode_residue,
               input best_multiplicity, input best_prime, input run_residue,
               input primes_counted, input witness, output ready);
endinterface

interface frms_cfg_if;
  import frms_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> design/frms_divider.sv
module frms_divider
  import frms_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  frms_div_req_t req,
  output frms_div_rsp_t rsp
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] steps;
  logic [32:0]          dsh;
  logic [32:0]          quot;
  logic [CAND_W-1:0]    rem;
  logic [CAND_W-1:0]    divisor;
  logic                 done;
  logic [CAND_W:0]      trial;
  logic                 fits;

  // One restoring step per cycle
  assign trial = {rem, dsh[32]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        busy <= 1'b1;
        steps <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && req.start) begin
      dsh     <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
      quot    <= '0;
    end else if (busy) begin
      dsh  <= {dsh[31:0], 1'b0};
      quot <= {quot[31:0], fits};
      rem  <= fits ? CAND_W'(trial - {1'b0, divisor}) : trial[CAND_W-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot[31:0];
  assign rsp.rem  = rem;

`ifndef SYNTHESIS
  // a finished remainder is always below the divisor
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < divisor)) else $error("divider remainder not reduced");
`endif

endmodule

>>> design/frms_modmul.sv
module frms_modmul
  import frms_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [CAND_W-1:0] modulus,
  input  logic [31:0]       recip,
  input  frms_mm_req_t      req,
  output frms_mm_rsp_t      rsp
);

  frms_mm_state_t    state, state_next;
  logic [31:0]       prod;
  logic [63:0]       wide;
  logic [CAND_W-1:0] q;
  logic [31:0]       qp;
  logic [17:0]       r;
  logic              done;

  // Stage sequence: product, quotient estimate, q*p, subtract, two fixes
  always_comb begin
    state_next = state;
    case (state)
      MM_IDLE: if (req.start) state_next = MM_QUOT;
      MM_QUOT: state_next = MM_QP;
      MM_QP:   state_next = MM_SUB;
      MM_SUB:  state_next = MM_FIX1;
      MM_FIX1: state_next = MM_FIX2;
      MM_FIX2: state_next = MM_IDLE;
      default: state_next = MM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MM_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == MM_FIX2);
    end
  end

  assign wide = prod * recip;

  // Barrett datapath, a register after every multiplication
  always_ff @(posedge clk) begin
    case (state)
      MM_IDLE: if (req.start) prod <= req.a * req.b;
      MM_QUOT: q  <= wide[32+CAND_W-1:32];
      MM_QP:   qp <= q * modulus;
      MM_SUB:  r  <= 18'(prod - qp);
      MM_FIX1: if (r >= {2'b0, modulus}) r <= r - {2'b0, modulus};
      MM_FIX2: if (r >= {2'b0, modulus}) r <= r - {2'b0, modulus};
      default: r <= r;
    endcase
  end

  assign rsp.done   = done;
  assign rsp.result = r[CAND_W-1:0];

`ifndef SYNTHESIS
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    done |-> (r < {2'b0, modulus})) else $error("modular product not reduced");
`endif

endmodule

>>> design/factorial_residue_mode_search_core.sv
// Factorial residue mode search.
// Channels: item carries one 16-bit candidate per beat, result returns one
// beat per candidate, cfg writes required_count (reset value 16) and is
// always ready; write it only while the block is idle.
// A candidate is tested by odd trial division through an iterative divider
// (up to sqrt(n)/2 odd divisors). For a prime p the block then forms a
// reciprocal, clears count entries below p, walks k! mod p with a Barrett
// multiplier and a read-modify-write of the count memory (each k passes
// through the multiplier stages and the registered memory read), and scans
// the counts.
// One item is in work at a time.
// The result sits in an output register, so the next item is taken while a
// result waits; a finished item waits only if that register is still full.
// Reset (synchronous, rst) clears the running best, prime count and witness;
// the count memory needs no clearing pass since each prime clears its range.
// Once a witness is latched every later item is answered as ignored.
module factorial_residue_mode_search_core
  import frms_pkg::*;
(
  input logic         clk,
  input logic         rst,
  frms_in_if.sink     item,
  frms_out_if.source  result,
  frms_cfg_if.sink    cfg
);

  frms_state_t        state, state_next;
  logic [CAND_W-1:0]  p;
  logic [TRIAL_W-1:0] d;
  logic [17:0]        d_sq;
  logic [31:0]        recip;
  logic [CAND_W-1:0]  ptr;
  logic [CAND_W-1:0]  k;
  logic [CAND_W-1:0]  fact;
  logic [COUNT_W-1:0] top;
  logic [CAND_W-1:0]  top_res;
  logic               look_valid;
  logic [CAND_W-1:0]  look_idx;
  logic               res_prime;
  logic               res_ignored;
  logic [COUNT_W-1:0] req_count;
  logic [COUNT_W-1:0] best_cnt;
  logic [CAND_W-1:0]  best_p;
  logic [CAND_W-1:0]  best_res;
  logic [CAND_W-1:0]  searched;
  logic               witness_q;
  logic               out_free;

  logic [COUNT_W-1:0] count_mem [0:TABLE_DEPTH-1];
  logic [CAND_W-1:0]  rd_addr;
  logic [COUNT_W-1:0] rd_data;
  logic               mem_we;
  logic [CAND_W-1:0]  wr_addr;
  logic [COUNT_W-1:0] wr_data;

  frms_div_req_t div_req;
  frms_div_rsp_t div_rsp;
  frms_mm_req_t  mm_req;
  frms_mm_rsp_t  mm_rsp;

  frms_divider u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));
  frms_modmul  u_mm (.clk(clk), .rst(rst), .modulus(p), .recip(recip),
                     .req(mm_req), .rsp(mm_rsp));

  assign d_sq     = {9'b0, d} * {9'b0, d};
  assign out_free = !result.valid || result.ready;
  assign cfg.ready = 1'b1;

  // Count memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) count_mem[wr_addr] <= wr_data;
    rd_data <= count_mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (item.valid) state_next = ST_CHECK;
      ST_CHECK: begin
        if (witness_q || p < CAND_W'(2)) state_next = ST_FINISH;
        else if (p == CAND_W'(2)) state_next = ST_RECIP_START;
        else if (!p[0]) state_next = ST_FINISH;
        else state_next = ST_TRIAL_TEST;
      end
      ST_TRIAL_TEST: begin
        if (d_sq > {2'b0, p}) state_next = ST_RECIP_START;
        else state_next = ST_TRIAL_WAIT;
      end
      ST_TRIAL_WAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) state_next = ST_FINISH;
          else state_next = ST_TRIAL_TEST;
        end
      end
      ST_RECIP_START: state_next = ST_RECIP_WAIT;
      ST_RECIP_WAIT: if (div_rsp.done) state_next = ST_CLEAR;
      ST_CLEAR: if (ptr == p - 1'b1) state_next = ST_CNT_RD;
      ST_CNT_RD: state_next = ST_CNT_WR;
      ST_CNT_WR: begin
        if (k == p - 1'b1) state_next = ST_SCAN;
        else state_next = ST_MUL_START;
      end
      ST_MUL_START: state_next = ST_MUL_WAIT;
      ST_MUL_WAIT: if (mm_rsp.done) state_next = ST_CNT_RD;
      ST_SCAN: if (ptr == p - 1'b1) state_next = ST_SCAN_LAST;
      ST_SCAN_LAST: state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    item.ready      = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {24'b0, d};
    div_req.divisor  = {7'b0, d};
    mm_req.start     = 1'b0;
    mm_req.a         = fact;
    mm_req.b         = k;
    mem_we           = 1'b0;
    wr_addr          = fact;
    wr_data          = (rd_data == COUNT_MAX) ? COUNT_MAX : rd_data + 1'b1;
    rd_addr          = fact;
    case (state)
      ST_IDLE: item.ready = 1'b1;
      ST_TRIAL_TEST: begin
        div_req.start    = !(d_sq > {2'b0, p});
        div_req.dividend = {17'b0, p};
      end
      ST_RECIP_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b1, 32'b0};
        div_req.divisor  = p;
      end
      ST_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = ptr;
        wr_data = '0;
      end
      ST_CNT_WR: mem_we = 1'b1;
      ST_MUL_START: mm_req.start = 1'b1;
      ST_SCAN: rd_addr = ptr;
      default: mem_we = 1'b0;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      result.valid  <= 1'b0;
      req_count     <= REQ_DEFAULT;
      best_cnt      <= '0;
      best_p        <= '0;
      best_res      <= '0;
      searched      <= '0;
      witness_q     <= 1'b0;
      look_valid    <= 1'b0;
    end else begin
      state      <= state_next;
      look_valid <= (state == ST_SCAN);
      if (cfg.valid) req_count <= cfg.data;
      if (state == ST_RECIP_START && searched != PRIMES_MAX)
        searched <= searched + 1'b1;
      if (state == ST_UPDATE) begin
        if (top > best_cnt || top >= req_count) begin
          best_cnt <= top;
          best_p   <= p;
          best_res <= top_res;
        end
        if (top >= req_count) witness_q <= 1'b1;
      end
      if (state == ST_FINISH && out_free) result.valid <= 1'b1;
      else if (result.ready) result.valid <= 1'b0;
    end
  end

  // Per-item datapath
  always_ff @(posedge clk) begin
    look_idx <= ptr;
    case (state)
      ST_IDLE: begin
        p           <= item.candidate;
        d           <= TRIAL_W'(3);
        res_prime   <= 1'b0;
        res_ignored <= 1'b0;
        top         <= '0;
        top_res     <= '0;
      end
      ST_CHECK: res_ignored <= witness_q;
      ST_TRIAL_WAIT: if (div_rsp.done) d <= d + TRIAL_W'(2);
      ST_RECIP_WAIT: begin
        recip <= div_rsp.quot;
        ptr   <= '0;
      end
      ST_CLEAR: begin
        ptr  <= ptr + 1'b1;
        k    <= '0;
        fact <= CAND_W'(1);
      end
      ST_CNT_WR: begin
        k   <= k + 1'b1;
        ptr <= '0;
      end
      ST_MUL_WAIT: if (mm_rsp.done) fact <= mm_rsp.result;
      ST_SCAN: ptr <= ptr + 1'b1;
      ST_UPDATE: res_prime <= 1'b1;
      default: p <= p;
    endcase
    // Scan compare, in the cycle after the read address is issued
    if (look_valid && rd_data > top) begin
      top     <= rd_data;
      top_res <= look_idx;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      result.candidate_is_prime <= res_prime;
      result.item_ignored       <= res_ignored;
      result.local_multiplicity <= top;
      result.mode_residue       <= top_res;
      result.best_multiplicity  <= best_cnt;
      result.best_prime         <= best_p;
      result.run_residue        <= best_res;
      result.primes_counted     <= searched;
      result.witness            <= witness_q;
    end
  end

`ifndef SYNTHESIS
  a_witness_sticky: assert property (@(posedge clk) disable iff (rst)
    witness_q |=> witness_q) else $error("witness dropped");
  // the best only falls when a witness overwrites it
  a_best_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> best_cnt >= $past(best_cnt) || witness_q)
    else $error("best count fell");
  a_prime_not_ignored: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE |-> !res_ignored && !witness_q)
    else $error("search ran after witness");
`endif

endmodule
